/* rtl/cbd_pkg.sv */
// ----------------------------------------------------------------------------
// cbd_pkg
// Shared types and character constants for the chunked body decoder.
// ----------------------------------------------------------------------------
package cbd_pkg;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LOW_X = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;

    // one hex digit per size-line byte
    localparam int HEX_BITS = 4;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    // classified body byte, handed from front to back
    typedef struct packed {
        logic [7:0]          data;
        logic                last;
        logic                is_lf;
        logic                is_cr;
        logic                is_blank;
        logic                is_x;
        logic                is_hex;
        logic [HEX_BITS-1:0] hex_val;
    } cbd_item_t;

endpackage

/* rtl/cbd_front.sv */
// ----------------------------------------------------------------------------
// cbd_front
// Accepts body bytes and classifies them for the size-line parser.
// ----------------------------------------------------------------------------
module cbd_front (
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_in_byte,
    input  logic               s_in_last,
    output logic               wr_valid,
    input  logic               wr_ready,
    output cbd_pkg::cbd_item_t wr_item
);

    logic                         is_dec;
    logic                         is_lower;
    logic                         is_upper;
    logic [cbd_pkg::HEX_BITS-1:0] hex_val;

    always_comb begin
        is_dec   = (s_in_byte >= 8'h30) && (s_in_byte <= 8'h39);
        is_lower = (s_in_byte >= 8'h61) && (s_in_byte <= 8'h66);
        is_upper = (s_in_byte >= 8'h41) && (s_in_byte <= 8'h46);
        priority if (is_dec) begin
            hex_val = s_in_byte[cbd_pkg::HEX_BITS-1:0];
        end else if (is_lower || is_upper) begin
            // 'a'..'f' and 'A'..'F' share the low three bits 1..6
            hex_val = cbd_pkg::HEX_BITS'(s_in_byte[2:0] + 3'd1) + 4'd8;
        end else begin
            hex_val = '0;
        end
    end

    always_comb begin
        wr_item.data     = s_in_byte;
        wr_item.last     = s_in_last;
        wr_item.is_lf    = (s_in_byte == cbd_pkg::CH_LF);
        wr_item.is_cr    = (s_in_byte == cbd_pkg::CH_CR);
        wr_item.is_blank = (s_in_byte == cbd_pkg::CH_SP) || (s_in_byte == cbd_pkg::CH_TAB);
        wr_item.is_x     = (s_in_byte == cbd_pkg::CH_LOW_X) || (s_in_byte == cbd_pkg::CH_UP_X);
        wr_item.is_hex   = is_dec || is_lower || is_upper;
        wr_item.hex_val  = hex_val;
    end

    assign wr_valid = s_valid;
    assign s_ready  = wr_ready;

endmodule

/* rtl/cbd_fifo.sv */
// ----------------------------------------------------------------------------
// cbd_fifo
// Short queue of classified bytes between the front and back parts.
// ----------------------------------------------------------------------------
module cbd_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_valid,
    output logic               wr_ready,
    input  cbd_pkg::cbd_item_t wr_item,
    output logic               rd_valid,
    input  logic               rd_pop,
    output cbd_pkg::cbd_item_t rd_item
);

    cbd_pkg::cbd_item_t                 mem_reg [cbd_pkg::FIFO_DEPTH];
    logic [cbd_pkg::FIFO_AW-1:0]        wptr_reg;
    logic [cbd_pkg::FIFO_AW-1:0]        wptr_next;
    logic [cbd_pkg::FIFO_AW-1:0]        rptr_reg;
    logic [cbd_pkg::FIFO_AW-1:0]        rptr_next;
    logic [cbd_pkg::FIFO_CW-1:0]        count_reg;
    logic [cbd_pkg::FIFO_CW-1:0]        count_next;
    logic                               push;
    logic                               pop;

    assign wr_ready = (count_reg != cbd_pkg::FIFO_CW'(cbd_pkg::FIFO_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = mem_reg[rptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_pop && rd_valid;

    always_comb begin
        wptr_next  = push ? wptr_reg + cbd_pkg::FIFO_AW'(1) : wptr_reg;
        rptr_next  = pop ? rptr_reg + cbd_pkg::FIFO_AW'(1) : rptr_reg;
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + cbd_pkg::FIFO_CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - cbd_pkg::FIFO_CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= wr_item;
        end
    end

endmodule

/* rtl/cbd_back.sv */
// ----------------------------------------------------------------------------
// cbd_back
// Size-line parser and payload pass state machine with output register.
// ----------------------------------------------------------------------------
module cbd_back #(
    parameter int SIZE_BITS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               rd_valid,
    output logic               rd_pop,
    input  cbd_pkg::cbd_item_t rd_item,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_has_byte,
    output logic [7:0]         m_out_byte,
    output logic               m_finished,
    output logic [31:0]        m_decoded_count,
    output logic               m_out_last
);

    typedef enum logic [6:0] {
        MODE_LEAD    = 7'b0000001,
        MODE_DIGITS  = 7'b0000010,
        MODE_SKIP    = 7'b0000100,
        MODE_PAYLOAD = 7'b0001000,
        MODE_TRAILCR = 7'b0010000,
        MODE_TRAILLF = 7'b0100000,
        MODE_DONE    = 7'b1000000
    } cbd_mode_t;

    cbd_mode_t              mode_reg;
    cbd_mode_t              mode_next;
    cbd_mode_t              line_mode;
    logic [SIZE_BITS-1:0]   chunk_reg;
    logic [SIZE_BITS-1:0]   chunk_next;
    logic [SIZE_BITS-1:0]   left_reg;
    logic [SIZE_BITS-1:0]   left_next;
    logic [SIZE_BITS-1:0]   digit_size;
    logic                   lz_reg;
    logic                   lz_next;
    logic [31:0]            count_reg;
    logic [31:0]            count_next;
    logic                   line_byte;
    logic                   has;

    logic                   m_valid_reg;
    logic                   has_reg;
    logic [7:0]             byte_reg;
    logic                   fin_reg;
    logic [31:0]            cnt_out_reg;
    logic                   last_reg;

    assign rd_pop = rd_valid && (!m_valid_reg || m_ready);

    always_comb begin
        mode_next  = mode_reg;
        chunk_next = chunk_reg;
        left_next  = left_reg;
        lz_next    = lz_reg;
        count_next = count_reg;
        has        = 1'b0;
        line_byte  = 1'b0;
        line_mode  = MODE_LEAD;
        digit_size = '0;

        unique case (mode_reg)
            MODE_PAYLOAD: begin
                has = 1'b1;
                if (count_reg != '1) begin
                    count_next = count_reg + 32'd1;
                end
                left_next = left_reg - SIZE_BITS'(1);
                if (left_reg == SIZE_BITS'(1)) begin
                    mode_next = MODE_TRAILCR;
                end
            end
            MODE_TRAILCR: begin
                if (rd_item.is_cr) begin
                    mode_next = MODE_TRAILLF;
                end else begin
                    // restart the size line; a non-LF byte is its first byte
                    mode_next  = MODE_LEAD;
                    chunk_next = '0;
                    lz_next    = 1'b0;
                    line_byte  = !rd_item.is_lf;
                end
            end
            MODE_TRAILLF: begin
                mode_next  = MODE_LEAD;
                chunk_next = '0;
                lz_next    = 1'b0;
                line_byte  = !rd_item.is_lf;
            end
            MODE_LEAD, MODE_DIGITS, MODE_SKIP: begin
                line_byte = 1'b1;
                line_mode = mode_reg;
            end
            MODE_DONE: begin
                mode_next = MODE_DONE;
            end
            default: begin
                mode_next = MODE_DONE;
            end
        endcase

        // saturate once the top digit position is occupied
        if (|chunk_next[SIZE_BITS-1 -: cbd_pkg::HEX_BITS]) begin
            digit_size = '1;
        end else begin
            digit_size = {chunk_next[SIZE_BITS-cbd_pkg::HEX_BITS-1:0], rd_item.hex_val};
        end

        if (line_byte) begin
            if (rd_item.is_lf) begin
                if (chunk_next == '0) begin
                    mode_next = MODE_DONE;
                end else begin
                    left_next = chunk_next;
                    mode_next = MODE_PAYLOAD;
                end
            end else begin
                unique case (line_mode)
                    MODE_LEAD: begin
                        if (rd_item.is_hex) begin
                            chunk_next = digit_size;
                            lz_next    = (rd_item.hex_val == '0);
                            mode_next  = MODE_DIGITS;
                        end else if (!rd_item.is_blank) begin
                            mode_next = MODE_SKIP;
                        end
                    end
                    MODE_DIGITS: begin
                        if (lz_next && rd_item.is_x) begin
                            lz_next = 1'b0;
                        end else if (rd_item.is_hex) begin
                            chunk_next = digit_size;
                            lz_next    = 1'b0;
                        end else begin
                            mode_next = MODE_SKIP;
                        end
                    end
                    default: begin
                        // ignore up to LF
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_LEAD;
            chunk_reg   <= '0;
            left_reg    <= '0;
            lz_reg      <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (rd_pop) begin
                m_valid_reg <= 1'b1;
                if (rd_item.last) begin
                    // end of body: start the next one clean
                    mode_reg  <= MODE_LEAD;
                    chunk_reg <= '0;
                    left_reg  <= '0;
                    lz_reg    <= 1'b0;
                    count_reg <= '0;
                end else begin
                    mode_reg  <= mode_next;
                    chunk_reg <= chunk_next;
                    left_reg  <= left_next;
                    lz_reg    <= lz_next;
                    count_reg <= count_next;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_pop) begin
            has_reg     <= has;
            byte_reg    <= has ? rd_item.data : 8'h00;
            fin_reg     <= (mode_next == MODE_DONE);
            cnt_out_reg <= count_next;
            last_reg    <= rd_item.last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_has_byte      = has_reg;
    assign m_out_byte      = byte_reg;
    assign m_finished      = fin_reg;
    assign m_decoded_count = cnt_out_reg;
    assign m_out_last      = last_reg;

endmodule

/* rtl/chunked_body_decoder.sv */
// ----------------------------------------------------------------------------
// chunked_body_decoder
// Streaming decoder for an HTTP chunked transfer body, one byte per beat.
// ----------------------------------------------------------------------------
// Input channel (s_): one raw body byte per beat, s_in_last on the final
// byte of a body. Result channel (m_): exactly one beat per input beat;
// m_has_byte marks a payload byte, m_finished is set once the zero-size
// chunk has been seen, m_decoded_count counts payload bytes of this body
// (saturating), m_out_last echoes s_in_last.
// Throughput: one beat per cycle while the receiver does not stall (m_ready).
// The parser state machine handles one byte per cycle under the same stall
// condition, with a shift-add on the size and a decrement of the remaining
// count. An accepted byte is written into the classifier queue, and the
// output register loads its result when the parser pops it from the queue.
// A four-entry queue sits between the byte classifier and the parser, so
// input keeps flowing while the receiver stalls until the queue fills; the
// result beat then holds in the output register.
// Reset (aresetn low, synchronous) empties the queue, drops the output beat
// and returns the parser to the start of a size line. After a beat with
// s_in_last the parser restarts the same way for the next body.
// ----------------------------------------------------------------------------
module chunked_body_decoder #(
    parameter int SIZE_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_in_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_has_byte,
    output logic [7:0]  m_out_byte,
    output logic        m_finished,
    output logic [31:0] m_decoded_count,
    output logic        m_out_last
);

    logic               wr_valid;
    logic               wr_ready;
    cbd_pkg::cbd_item_t wr_item;
    logic               rd_valid;
    logic               rd_pop;
    cbd_pkg::cbd_item_t rd_item;

    cbd_front u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .s_in_last (s_in_last),
        .wr_valid  (wr_valid),
        .wr_ready  (wr_ready),
        .wr_item   (wr_item)
    );

    cbd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (wr_valid),
        .wr_ready (wr_ready),
        .wr_item  (wr_item),
        .rd_valid (rd_valid),
        .rd_pop   (rd_pop),
        .rd_item  (rd_item)
    );

    cbd_back #(
        .SIZE_BITS (SIZE_BITS)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .rd_valid        (rd_valid),
        .rd_pop          (rd_pop),
        .rd_item         (rd_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_has_byte      (m_has_byte),
        .m_out_byte      (m_out_byte),
        .m_finished      (m_finished),
        .m_decoded_count (m_decoded_count),
        .m_out_last      (m_out_last)
    );

endmodule

/* rtl/cbd_checker.sv */
// ----------------------------------------------------------------------------
// cbd_checker
// Port-level checks on the chunked body decoder result channel.
// ----------------------------------------------------------------------------
module cbd_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_has_byte,
    input  logic [7:0]  m_out_byte,
    input  logic        m_finished,
    input  logic [31:0] m_decoded_count,
    input  logic        m_out_last
);

    // hold a stalled beat
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_has_byte) && $stable(m_out_byte)
            && $stable(m_finished) && $stable(m_decoded_count) && $stable(m_out_last))
        else $error("result beat changed while stalled");

    a_zero_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_has_byte |-> m_out_byte == 8'h00)
        else $error("non-payload beat carries a byte");

    a_payload_not_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_has_byte |-> !m_finished)
        else $error("payload byte after terminating chunk");

    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_has_byte |-> m_decoded_count != 32'd0)
        else $error("payload byte with zero count");

endmodule

bind chunked_body_decoder cbd_checker u_cbd_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_has_byte      (m_has_byte),
    .m_out_byte      (m_out_byte),
    .m_finished      (m_finished),
    .m_decoded_count (m_decoded_count),
    .m_out_last      (m_out_last)
);

/* dv/chunked_body_decoder_tb.sv */
// ----------------------------------------------------------------------------
// chunked_body_decoder_tb
// Self-checking bench for the chunked body decoder. Short hand-built bodies
// cover the corner cases of the size line. Random well-formed bodies, broken
// ones and noise follow under changing idle patterns on both channels, with
// one long receiver hold-off. Every result beat is checked against a
// byte-level parser model kept in the bench.
// ----------------------------------------------------------------------------
module chunked_body_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        ST_LEAD, ST_DIGITS, ST_SKIP, ST_PAYLOAD, ST_TRAIL_CR, ST_TRAIL_LF, ST_DONE
    } parse_mode_t;

    typedef struct packed {
        logic        has_byte;
        logic [7:0]  out_byte;
        logic        finished;
        logic [31:0] count;
        logic        last;
    } decoded_beat_t;

    localparam logic [31:0] SIZE_MAX = '1;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte = 8'h00;
    logic        s_in_last = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_has_byte;
    logic [7:0]  m_out_byte;
    logic        m_finished;
    logic [31:0] m_decoded_count;
    logic        m_out_last;

    // parser model state
    parse_mode_t pmode;
    logic [31:0] psize;
    logic [31:0] premain;
    logic        pzero_only;
    logic [31:0] pcount;

    decoded_beat_t expected_q[$];
    logic [7:0]    body_q[$];

    int errors = 0;
    int beats_sent = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req_count = 0;
    int hold_len = 0;
    int hold_seen = 0;
    int hold_left = 0;

    chunked_body_decoder DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .s_in_last       (s_in_last),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_has_byte      (m_has_byte),
        .m_out_byte      (m_out_byte),
        .m_finished      (m_finished),
        .m_decoded_count (m_decoded_count),
        .m_out_last      (m_out_last)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // parser model
    // ------------------------------------------------------------------
    function automatic int hex_nibble(logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    function automatic void restart_line();
        pmode = ST_LEAD;
        psize = '0;
        pzero_only = 1'b0;
    endfunction

    function automatic void reset_parser();
        restart_line();
        premain = '0;
        pcount = '0;
    endfunction

    // saturate once another nibble would overflow
    function automatic void shift_in_nibble(logic [3:0] d);
        if (psize > (SIZE_MAX >> 4))
            psize = SIZE_MAX;
        else
            psize = {psize[27:0], d};
    endfunction

    function automatic void size_line_byte(logic [7:0] c);
        int h;
        h = hex_nibble(c);
        if (c == cbd_pkg::CH_LF) begin
            if (psize == '0) begin
                pmode = ST_DONE;
            end else begin
                premain = psize;
                pmode = ST_PAYLOAD;
            end
        end else if (pmode == ST_LEAD) begin
            if (c != cbd_pkg::CH_SP && c != cbd_pkg::CH_TAB) begin
                if (h >= 0) begin
                    psize = '0;
                    shift_in_nibble(4'(h));
                    pzero_only = (h == 0);
                    pmode = ST_DIGITS;
                end else begin
                    pmode = ST_SKIP;
                end
            end
        end else if (pmode == ST_DIGITS) begin
            if (pzero_only && (c == cbd_pkg::CH_LOW_X || c == cbd_pkg::CH_UP_X)) begin
                pzero_only = 1'b0;
            end else if (h >= 0) begin
                shift_in_nibble(4'(h));
                pzero_only = 1'b0;
            end else begin
                pmode = ST_SKIP;
            end
        end
    endfunction

    function automatic decoded_beat_t decode_byte(logic [7:0] c, logic last);
        decoded_beat_t r;
        r = '0;
        case (pmode)
            ST_PAYLOAD: begin
                r.has_byte = 1'b1;
                r.out_byte = c;
                if (pcount != '1) pcount = pcount + 32'd1;
                premain = premain - 32'd1;
                if (premain == '0) pmode = ST_TRAIL_CR;
            end
            ST_TRAIL_CR: begin
                if (c == cbd_pkg::CH_CR) begin
                    pmode = ST_TRAIL_LF;
                end else begin
                    restart_line();
                    if (c != cbd_pkg::CH_LF) size_line_byte(c);
                end
            end
            ST_TRAIL_LF: begin
                restart_line();
                if (c != cbd_pkg::CH_LF) size_line_byte(c);
            end
            ST_LEAD, ST_DIGITS, ST_SKIP: begin
                size_line_byte(c);
            end
            default: begin
                pmode = ST_DONE;
            end
        endcase
        r.finished = (pmode == ST_DONE);
        r.count = pcount;
        r.last = last;
        if (last) reset_parser();
        return r;
    endfunction

    // ------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------
    task automatic send_beat(logic [7:0] c, logic last);
        logic accepted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_in_byte <= c;
        s_in_last <= last;
        accepted = 1'b0;
        // sample the handshake mid-cycle, away from the driving edge
        while (!accepted) begin
            @(negedge aclk);
            accepted = s_ready;
            @(posedge aclk);
        end
        expected_q.push_back(decode_byte(c, last));
        beats_sent++;
    endtask

    task automatic send_body();
        int i;
        for (i = 0; i < body_q.size(); i++)
            send_beat(body_q[i], i == body_q.size() - 1);
        body_q.delete();
    endtask

    task automatic queue_text(string s);
        int i;
        for (i = 0; i < s.len(); i++)
            body_q.push_back(s[i]);
    endtask

    function automatic logic [7:0] hex_char(int v);
        if (v < 10) return 8'(int'("0") + v);
        return 8'(($urandom_range(1) ? int'("a") : int'("A")) + v - 10);
    endfunction

    task automatic add_size_line(logic [31:0] size);
        int n;
        int i;
        if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 2))
                body_q.push_back($urandom_range(1) ? cbd_pkg::CH_SP : cbd_pkg::CH_TAB);
        end
        if ($urandom_range(4) == 0) queue_text($urandom_range(1) ? "0x" : "0X");
        if ($urandom_range(9) == 0) body_q.push_back("0");
        n = 1;
        while (n < 8 && (size >> (4 * n)) != '0) n++;
        for (i = n - 1; i >= 0; i--)
            body_q.push_back(hex_char(int'(size[4*i +: 4])));
        if ($urandom_range(4) == 0) queue_text(";ext=v");
        if ($urandom_range(9) != 0) body_q.push_back(cbd_pkg::CH_CR);
        body_q.push_back(cbd_pkg::CH_LF);
    endtask

    task automatic build_random_body();
        int kind;
        int r;
        int keep;
        logic [31:0] size;
        kind = $urandom_range(99);
        if (kind < 5) begin
            // plain noise
            repeat ($urandom_range(1, 10)) body_q.push_back(8'($urandom_range(255)));
        end else if (kind < 9) begin
            // oversized chunk: saturate, then cut the body short
            if ($urandom_range(1)) queue_text("0x");
            body_q.push_back(hex_char($urandom_range(1, 15)));
            repeat ($urandom_range(8, 10)) body_q.push_back(hex_char($urandom_range(15)));
            if ($urandom_range(1)) body_q.push_back(cbd_pkg::CH_CR);
            body_q.push_back(cbd_pkg::CH_LF);
            repeat ($urandom_range(1, 3)) body_q.push_back(8'($urandom_range(255)));
        end else begin
            repeat ($urandom_range(3)) begin
                size = ($urandom_range(9) == 0) ? $urandom_range(16, 64)
                                                : $urandom_range(1, 12);
                add_size_line(size);
                repeat (size) body_q.push_back(8'($urandom_range(255)));
                r = $urandom_range(99);
                if (r < 80) begin
                    body_q.push_back(cbd_pkg::CH_CR);
                    body_q.push_back(cbd_pkg::CH_LF);
                end else if (r < 87) begin
                    body_q.push_back(cbd_pkg::CH_CR);
                end else if (r < 94) begin
                    body_q.push_back(cbd_pkg::CH_LF);
                end
            end
            add_size_line('0);
            r = $urandom_range(9);
            if (r < 5) begin
                body_q.push_back(cbd_pkg::CH_CR);
                body_q.push_back(cbd_pkg::CH_LF);
            end else if (r < 7) begin
                repeat ($urandom_range(1, 4)) body_q.push_back(8'($urandom_range(255)));
            end
            if ($urandom_range(9) == 0) begin
                keep = $urandom_range(1, body_q.size());
                while (body_q.size() > keep) void'(body_q.pop_back());
            end
            if ($urandom_range(19) == 0)
                body_q[$urandom_range(body_q.size() - 1)] = 8'($urandom_range(255));
        end
    endtask

    // ------------------------------------------------------------------
    // receiver
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_seen != hold_req_count) begin
            hold_seen = hold_req_count;
            hold_left = hold_len;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= 20)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    always @(negedge aclk) begin
        decoded_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 20)
                    $display("%0t: result beat with none expected, got byte %0h count %0h",
                             $time, m_out_byte, m_decoded_count);
            end else begin
                want = expected_q.pop_front();
                check_field("has_byte", 32'(want.has_byte), 32'(m_has_byte));
                check_field("out_byte", 32'(want.out_byte), 32'(m_out_byte));
                check_field("finished", 32'(want.finished), 32'(m_finished));
                check_field("decoded_count", want.count, m_decoded_count);
                check_field("out_last", 32'(want.last), 32'(m_out_last));
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed_cases();
        // empty size line ends the body at once
        body_q.push_back(cbd_pkg::CH_LF);
        send_body();
        // prefix with no digits
        queue_text("0X");
        body_q.push_back(cbd_pkg::CH_LF);
        send_body();
        // CR ahead of the digits voids the line; later bytes drop
        body_q.push_back(cbd_pkg::CH_CR);
        queue_text("1");
        body_q.push_back(cbd_pkg::CH_LF);
        queue_text("Z");
        send_body();
        // extension, then a size digit right after the payload, cut mid-chunk
        queue_text("0x1;");
        body_q.push_back(cbd_pkg::CH_LF);
        body_q.push_back(8'hFF);
        queue_text("2");
        body_q.push_back(cbd_pkg::CH_LF);
        body_q.push_back(8'h00);
        send_body();
        // nine digits saturate the size
        body_q.push_back(cbd_pkg::CH_TAB);
        body_q.push_back(cbd_pkg::CH_SP);
        queue_text("1ffffffff");
        body_q.push_back(cbd_pkg::CH_LF);
        body_q.push_back(8'h5A);
        send_body();
    endtask

    task automatic test_random_bodies(int beats);
        int stop;
        stop = beats_sent + beats;
        while (beats_sent < stop) begin
            build_random_body();
            send_body();
        end
    endtask

    // hold the result side long enough for the input to back up
    task automatic test_receiver_holdoff();
        hold_len = 80;
        hold_req_count++;
        queue_text("18");
        body_q.push_back(cbd_pkg::CH_CR);
        body_q.push_back(cbd_pkg::CH_LF);
        repeat (24) body_q.push_back(8'($urandom_range(255)));
        body_q.push_back(cbd_pkg::CH_CR);
        body_q.push_back(cbd_pkg::CH_LF);
        queue_text("0");
        body_q.push_back(cbd_pkg::CH_CR);
        body_q.push_back(cbd_pkg::CH_LF);
        send_body();
    endtask

    initial begin
        int waited;
        reset_parser();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 12;
        recv_idle_pct = 74;
        test_directed_cases();
        test_random_bodies(230);

        send_idle_pct = 74;
        recv_idle_pct = 12;
        test_random_bodies(230);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_receiver_holdoff();
        test_random_bodies(230);
        s_valid <= 1'b0;

        for (waited = 0; expected_q.size() != 0 && waited < 20000; waited++)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (errors == 0 && expected_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
